@@ rtl/isd_pkg.sv @@
// Shared constants and controller/datapath interface types for the
// integer stream deduplicator. No dependencies.
`timescale 1ns / 1ps

package isd_pkg;

  localparam int TABLE_SLOTS = 1024;
  localparam int MAX_LEN     = 512;

  localparam int IDX_W    = $clog2(TABLE_SLOTS);
  localparam int CNT_W    = $clog2(MAX_LEN + 1);
  localparam int UCOUNT_W = 10;
  localparam int VALUE_W  = 32;
  localparam int EPOCH_W  = 8;

  localparam logic [31:0] HASH_MULT_RESET = 32'd2654435769;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic load_addr;
    logic rd_en;
    logic step;
    logic insert;
    logic res_set;
    logic res_new;
    logic res_ovf;
    logic emit;
    logic list_end;
    logic clr_write;
  } isd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_empty;
    logic slot_match;
    logic count_full;
    logic probe_last;
    logic out_free;
    logic cur_last;
    logic epoch_wrap;
    logic clr_last;
  } isd_status_t;

endpackage

@@ rtl/isd_ctrl.sv @@
// Controller state machine for the integer stream deduplicator.
// Depends on isd_pkg for the command and status types.
`timescale 1ns / 1ps

module isd_ctrl
  import isd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  isd_status_t status,
  output isd_cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_HASH;
        end
      end
      S_HASH: begin
        cmd.load_addr = 1'b1;
        state_next    = S_READ;
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (status.slot_empty) begin
          cmd.res_set = 1'b1;
          if (status.count_full) begin
            cmd.res_ovf = 1'b1;
          end else begin
            cmd.insert  = 1'b1;
            cmd.res_new = 1'b1;
          end
          state_next = S_EMIT;
        end else if (status.slot_match) begin
          cmd.res_set = 1'b1;
          state_next  = S_EMIT;
        end else if (status.probe_last) begin
          // Whole table walked without a match or a free slot.
          cmd.res_set = 1'b1;
          cmd.res_ovf = 1'b1;
          state_next  = S_EMIT;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_READ;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.cur_last) begin
            cmd.list_end = 1'b1;
            state_next   = status.epoch_wrap ? S_CLEAR : S_IDLE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_to_hash: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_HASH))
    else $error("accepted request did not start hashing");
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_write |-> !in_ready)
    else $error("request accepted during clearing pass");
  a_state_legal: assert property (@(posedge clk) disable iff (rst)
    state <= S_EMIT)
    else $error("controller left its legal states");
`endif

endmodule

@@ rtl/isd_datapath.sv @@
// Datapath for the integer stream deduplicator: hash, slot memory with
// epoch tags, probe counters, kept count and output register. Uses isd_pkg.
`timescale 1ns / 1ps

module isd_datapath
  import isd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [31:0]          cfg_wdata,
  input  logic signed [31:0]   value,
  input  logic                 last_item,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic signed [31:0]   value_out,
  output logic                 is_new,
  output logic [UCOUNT_W-1:0]  unique_count,
  output logic                 overflow,
  output logic                 last_out,
  input  isd_cmd_t             cmd,
  output isd_status_t          status
);

  localparam int MEM_W = EPOCH_W + VALUE_W;

  // Only the low index bits of the multiplier reach the low index bits of
  // the product, so only those are kept.
  logic [IDX_W-1:0]   hash_mult;
  logic [VALUE_W-1:0] cur_value;
  logic               cur_last;
  logic [IDX_W-1:0]   addr;
  logic [IDX_W-1:0]   probes;
  logic [CNT_W-1:0]   kept_count;
  logic [EPOCH_W-1:0] epoch;
  logic [IDX_W-1:0]   clr_addr;
  logic               res_new;
  logic               res_ovf;
  logic [MEM_W-1:0]   mem [TABLE_SLOTS];
  logic [MEM_W-1:0]   rd_data;
  logic [2*IDX_W-1:0] hash_prod;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [MEM_W-1:0]   mem_wdata;
  logic [EPOCH_W-1:0] rd_tag;
  logic [VALUE_W-1:0] rd_val;

  assign hash_prod = cur_value[IDX_W-1:0] * hash_mult;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_mult <= HASH_MULT_RESET[IDX_W-1:0];
    end else if (cfg_wen) begin
      hash_mult <= cfg_wdata[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur_value <= value;
      cur_last  <= last_item;
    end
    if (cmd.load_addr) begin
      addr   <= hash_prod[IDX_W-1:0];
      probes <= '0;
    end else if (cmd.step) begin
      addr   <= addr + 1'b1;
      probes <= probes + 1'b1;
    end
    if (cmd.res_set) begin
      res_new <= cmd.res_new;
      res_ovf <= cmd.res_ovf;
    end
  end

  // Slot memory: each entry holds the epoch it was written in and the value.
  // An entry whose tag differs from the current epoch is an empty slot.
  assign mem_we    = cmd.insert | cmd.clr_write;
  assign mem_waddr = cmd.clr_write ? clr_addr : addr;
  assign mem_wdata = cmd.clr_write ? '0 : {epoch, cur_value};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[addr];
    end
  end

  assign rd_tag = rd_data[MEM_W-1:VALUE_W];
  assign rd_val = rd_data[VALUE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count <= '0;
      epoch      <= EPOCH_W'(1);
      clr_addr   <= '0;
    end else begin
      if (cmd.clr_write) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.list_end) begin
        kept_count <= '0;
        // Tag zero is reserved for cleared slots, so a wrap restarts at one.
        epoch <= (epoch == '1) ? EPOCH_W'(1) : epoch + 1'b1;
      end else if (cmd.insert) begin
        kept_count <= kept_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      value_out    <= cur_value;
      is_new       <= res_new;
      overflow     <= res_ovf;
      last_out     <= cur_last;
      unique_count <= UCOUNT_W'(kept_count);
    end
  end

  always_comb begin
    status.slot_empty = (rd_tag != epoch);
    status.slot_match = (rd_tag == epoch) && (rd_val == cur_value);
    status.count_full = (kept_count >= CNT_W'(MAX_LEN));
    status.probe_last = (probes == IDX_W'(TABLE_SLOTS - 1));
    status.out_free   = !out_valid || out_ready;
    status.cur_last   = cur_last;
    status.epoch_wrap = (epoch == '1);
    status.clr_last   = (clr_addr == IDX_W'(TABLE_SLOTS - 1));
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    kept_count <= CNT_W'(MAX_LEN))
    else $error("kept count exceeds list limit");
  a_insert_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> (status.slot_empty && !status.count_full))
    else $error("insert into an occupied slot or a full set");
  a_epoch_nonzero: assert property (@(posedge clk) disable iff (rst)
    epoch != '0)
    else $error("current epoch equals the cleared tag");
  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("output register overwritten while held");
`endif

endmodule

@@ rtl/integer_stream_deduplicator_unit.sv @@
// Top level of the integer stream deduplicator.
// Instantiates isd_ctrl and isd_datapath; uses isd_pkg.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid/in_ready) carries one signed 32-bit value and a
// last_item flag per request. The output channel (out_valid/out_ready) returns
// one result per request: the value, is_new, overflow, unique_count and
// last_out. After a request with last_item set, the set is empty for the next
// list.
// Each request passes through the hash, read and compare states before its
// result is loaded in the emit state; every further slot of the probe run adds
// another read and compare, since the slot memory read is registered. in_ready
// rises as the previous result appears in the output register, so a new
// request is taken only after the unit is through with the last one.
// If the receiver stalls, the result holds in the output register and the
// next request is processed but waits before loading its result.
// After reset, a clearing pass over all 1024 slots runs with in_ready low. The
// same pass runs after every 255th list, when the slot epoch tag wraps.
// cfg_wen writes hash_multiplier (reset 2654435769; only its low 10 bits are
// kept); written between lists, it changes probe lengths only, never results.

module integer_stream_deduplicator_unit
  import isd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  value,
  input  logic                last_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  value_out,
  output logic                is_new,
  output logic [UCOUNT_W-1:0] unique_count,
  output logic                overflow,
  output logic                last_out
);

  isd_cmd_t    cmd;
  isd_status_t status;

  isd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  isd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .value        (value),
    .last_item    (last_item),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .value_out    (value_out),
    .is_new       (is_new),
    .unique_count (unique_count),
    .overflow     (overflow),
    .last_out     (last_out),
    .cmd          (cmd),
    .status       (status)
  );

endmodule
